FILE: design/pci_pkg.sv
// ----------------------------------------------------------------------------
// pci_pkg: shared types and constants for the particle update pipeline
// Widths of the divider lanes, register codes and saturation helper.
// ----------------------------------------------------------------------------
package pci_pkg;

  localparam int QW    = 34;  // quotient bits per divider lane
  localparam int NW    = 56;  // dividend / remainder width
  localparam int DW    = 42;  // divisor width (1000 * mass)
  localparam int CW    = DW + QW;
  localparam int LANES = 3;   // three velocity lanes

  localparam logic signed [50:0] EPS_Q30   = 51'sd1073742;
  localparam logic [47:0]        POS_HALF  = 48'd128000;
  localparam logic [37:0]        POS_RECIP = 38'd140737488356;  // ceil(2^44 / 125)

  typedef enum logic [2:0] {
    REG_PLANE_A_POINT  = 3'd0,
    REG_PLANE_A_NORMAL = 3'd1,
    REG_PLANE_B_POINT  = 3'd2,
    REG_PLANE_B_NORMAL = 3'd3,
    REG_PLANE_COUNT    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] frc;
    logic [31:0]      mass;
    logic             active;
    logic [15:0]      dt;
  } part_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic             active;
    logic             mzero;
  } side_t;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [DW-1:0] den;
    logic [QW-1:0] quo;
    logic          neg;
    logic          ovf;
  } div_lane_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [15:0] comp16(input logic [47:0] w, input logic [1:0] i);
    return w[16*i +: 16];
  endfunction

endpackage

FILE: design/pci_in_if.sv
// ----------------------------------------------------------------------------
// pci_in_if: particle request channel
// Valid/ready handshake carrying one particle.
// ----------------------------------------------------------------------------
interface pci_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [31:0] vel_z;
  logic [31:0] force_x;
  logic [31:0] force_y;
  logic [31:0] force_z;
  logic [31:0] mass;
  logic        active;
  logic [15:0] step_time;

  modport source(output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 force_x, force_y, force_z, mass, active, step_time,
                 input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               force_x, force_y, force_z, mass, active, step_time,
               output ready);
endinterface

FILE: design/pci_out_if.sv
// ----------------------------------------------------------------------------
// pci_out_if: updated particle channel
// Valid/ready handshake carrying the new position and velocity.
// ----------------------------------------------------------------------------
interface pci_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_pos_x;
  logic [31:0] new_pos_y;
  logic [31:0] new_pos_z;
  logic [31:0] new_vel_x;
  logic [31:0] new_vel_y;
  logic [31:0] new_vel_z;

  modport source(output valid, new_pos_x, new_pos_y, new_pos_z,
                 new_vel_x, new_vel_y, new_vel_z, input ready);
  modport sink(input valid, new_pos_x, new_pos_y, new_pos_z,
               new_vel_x, new_vel_y, new_vel_z, output ready);
endinterface

FILE: design/particle_collide_integrate.sv
// ----------------------------------------------------------------------------
// particle_collide_integrate: plane reflection and Euler step per particle
// Fully pipelined; one particle request accepted per clock unless the output stalls.
// ----------------------------------------------------------------------------
// One particle enters per cycle unless the pipe holds; its path runs through
// eight stages of plane test and reflection, one of time products and
// divisor, a prep stage, 34 stages of a restoring divider that retires one
// quotient bit per stage for the three velocity lanes, and the output
// register. Position steps divide by a constant through a reciprocal
// multiply and are delayed to meet the divider. The divider length is what
// sets the latency. The whole pipe holds while a result waits on the output;
// the plane registers must only be written while the pipe is empty.
module particle_collide_integrate import pci_pkg::*; #(
  parameter int MAX_PLANES = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  pci_in_if.sink      particle,
  pci_out_if.source   result
);

  logic [47:0] pa_pt, pa_n, pb_pt, pb_n;
  logic [1:0]  plane_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_pt       <= '0;
      pa_n        <= '0;
      pb_pt       <= '0;
      pb_n        <= '0;
      plane_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PLANE_A_POINT:  pa_pt <= cfg_data;
        REG_PLANE_A_NORMAL: pa_n  <= cfg_data;
        REG_PLANE_B_POINT:  pb_pt <= cfg_data;
        REG_PLANE_B_NORMAL: pb_n  <= cfg_data;
        REG_PLANE_COUNT:    plane_count <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic use_a, use_b;
  assign use_a = (plane_count != 2'd0);
  assign use_b = (plane_count >= 2'd2) && (MAX_PLANES >= 2);

  logic out_valid, adv;
  assign adv            = !out_valid || result.ready;
  assign particle.ready = adv;
  assign result.valid   = out_valid;

  part_t in_p;
  always_comb begin
    in_p.pos    = {particle.pos_z, particle.pos_y, particle.pos_x};
    in_p.vel    = {particle.vel_z, particle.vel_y, particle.vel_x};
    in_p.frc    = {particle.force_z, particle.force_y, particle.force_x};
    in_p.mass   = particle.mass;
    in_p.active = particle.active;
    in_p.dt     = particle.step_time;
  end

  logic [9:1] vs;
  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (adv) begin
      vs <= {vs[8:1], particle.valid};
    end
  end

  // stage 1: distance and approach products
  part_t s1_p;
  logic signed [48:0] s1_da [3], s1_db [3], da_c [3], db_c [3];
  logic signed [47:0] s1_pa [3], pa_c [3];
  always_comb begin
    logic signed [32:0] dfa, dfb;
    logic signed [15:0] ca, cb;
    for (int i = 0; i < 3; i++) begin
      ca  = comp16(pa_pt, 2'(i));
      cb  = comp16(pb_pt, 2'(i));
      dfa = $signed({in_p.pos[i][31], in_p.pos[i]})
            - $signed({{9{ca[15]}}, ca, 8'b0});
      dfb = $signed({in_p.pos[i][31], in_p.pos[i]})
            - $signed({{9{cb[15]}}, cb, 8'b0});
      da_c[i] = dfa * comp16(pa_n, 2'(i));
      db_c[i] = dfb * comp16(pb_n, 2'(i));
      pa_c[i] = $signed(in_p.vel[i]) * comp16(pa_n, 2'(i));
    end
  end

  // stage 2: sums
  part_t s2_p;
  logic signed [50:0] s2_da, s2_db;
  logic signed [49:0] s2_pa;

  // stage 3: plane A hit, reflection products
  part_t s3_p;
  logic signed [50:0] s3_db;
  logic               s3_hit;
  logic signed [53:0] s3_qn [3], qna_c [3];
  logic               hita_c;
  always_comb begin
    logic signed [49:0] t;
    logic signed [35:0] q;
    hita_c = use_a && s2_p.active && (s2_da < EPS_Q30) && (s2_pa < 50'sd0);
    t = (s2_pa + 50'sd8192) >>> 14;
    q = t[35:0];
    for (int i = 0; i < 3; i++) begin
      qna_c[i] = (q * comp16(pa_n, 2'(i))) <<< 1;
    end
  end

  // stage 4: reflected velocity after plane A
  part_t s4_p;
  logic signed [50:0] s4_db;
  logic [2:0][31:0]   v1_c;
  always_comb begin
    logic signed [63:0] t;
    for (int i = 0; i < 3; i++) begin
      t = (64'(s3_qn[i]) + 64'sd8192) >>> 14;
      v1_c[i] = s3_hit ? sat32(64'($signed(s3_p.vel[i])) - t) : s3_p.vel[i];
    end
  end

  // stage 5: approach products against plane B
  part_t s5_p;
  logic signed [50:0] s5_db;
  logic signed [47:0] s5_pb [3], pb_c [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pb_c[i] = $signed(s4_p.vel[i]) * comp16(pb_n, 2'(i));
    end
  end

  // stage 6: sum
  part_t s6_p;
  logic signed [50:0] s6_db;
  logic signed [49:0] s6_pb;

  // stage 7: plane B hit
  part_t s7_p;
  logic               s7_hit;
  logic signed [53:0] s7_qn [3], qnb_c [3];
  logic               hitb_c;
  always_comb begin
    logic signed [49:0] t;
    logic signed [35:0] q;
    hitb_c = use_b && s6_p.active && (s6_db < EPS_Q30) && (s6_pb < 50'sd0);
    t = (s6_pb + 50'sd8192) >>> 14;
    q = t[35:0];
    for (int i = 0; i < 3; i++) begin
      qnb_c[i] = (q * comp16(pb_n, 2'(i))) <<< 1;
    end
  end

  // stage 8: reflected velocity after plane B
  part_t s8_p;
  logic [2:0][31:0] v2_c;
  always_comb begin
    logic signed [63:0] t;
    for (int i = 0; i < 3; i++) begin
      t = (64'(s7_qn[i]) + 64'sd8192) >>> 14;
      v2_c[i] = s7_hit ? sat32(64'($signed(s7_p.vel[i])) - t) : s7_p.vel[i];
    end
  end

  // stage 9: time products and divisor
  side_t              s9_s;
  logic signed [47:0] s9_pp [3], s9_pf [3], pp_c [3], pf_c [3];
  logic [DW-1:0]      s9_den;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pp_c[i] = $signed({1'b0, s8_p.dt}) * $signed(s8_p.vel[i]);
      pf_c[i] = $signed({1'b0, s8_p.dt}) * $signed(s8_p.frc[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_p <= in_p;
      s1_da <= da_c;
      s1_db <= db_c;
      s1_pa <= pa_c;

      s2_p  <= s1_p;
      s2_da <= 51'(s1_da[0]) + 51'(s1_da[1]) + 51'(s1_da[2]);
      s2_db <= 51'(s1_db[0]) + 51'(s1_db[1]) + 51'(s1_db[2]);
      s2_pa <= 50'(s1_pa[0]) + 50'(s1_pa[1]) + 50'(s1_pa[2]);

      s3_p   <= s2_p;
      s3_db  <= s2_db;
      s3_hit <= hita_c;
      s3_qn  <= qna_c;

      s4_p  <= '{pos: s3_p.pos, vel: v1_c, frc: s3_p.frc, mass: s3_p.mass,
                 active: s3_p.active, dt: s3_p.dt};
      s4_db <= s3_db;

      s5_p  <= s4_p;
      s5_db <= s4_db;
      s5_pb <= pb_c;

      s6_p  <= s5_p;
      s6_db <= s5_db;
      s6_pb <= 50'(s5_pb[0]) + 50'(s5_pb[1]) + 50'(s5_pb[2]);

      s7_p   <= s6_p;
      s7_hit <= hitb_c;
      s7_qn  <= qnb_c;

      s8_p <= '{pos: s7_p.pos, vel: v2_c, frc: s7_p.frc, mass: s7_p.mass,
                active: s7_p.active, dt: s7_p.dt};

      s9_s.pos    <= s8_p.pos;
      s9_s.vel    <= s8_p.vel;
      s9_s.active <= s8_p.active;
      s9_s.mzero  <= (s8_p.mass == 32'd0);
      s9_pp       <= pp_c;
      s9_pf       <= pf_c;
      s9_den      <= DW'(s8_p.mass) * 42'd1000;
    end
  end

  // prep: sign-magnitude dividends with rounding bias
  div_lane_t   prep_c [LANES];
  logic [36:0] pm1_c [3];
  logic        pneg_c [3];
  always_comb begin
    logic signed [NW-1:0] num;
    logic [NW-1:0]        mag;
    logic signed [47:0]   pv;
    logic [47:0]          pmag;
    for (int i = 0; i < 3; i++) begin
      pv        = s9_pp[i];
      pmag      = pv[47] ? 48'(-pv) : 48'(pv);
      pmag      = pmag + POS_HALF;
      pm1_c[i]  = pmag[47:11];
      pneg_c[i] = pv[47];

      num = {s9_pf[i], 8'b0};
      mag = num[NW-1] ? NW'(-num) : NW'(num);
      prep_c[i].neg = num[NW-1];
      prep_c[i].rem = mag + NW'(s9_den >> 1);
      prep_c[i].den = s9_den;
      prep_c[i].quo = '0;
      prep_c[i].ovf = 1'b0;
    end
  end

  // position lanes: m / 256000 = (m >> 11) / 125, by reciprocal multiply
  logic [36:0]        pm1 [3];
  logic               pneg1 [3], pneg2 [3];
  logic [37:0]        phh [3], phl [3], plh [3], pll [3];
  logic signed [30:0] pq_c [3];
  logic signed [30:0] pd [2:QW][3];
  always_comb begin
    logic [75:0] full;
    logic [29:0] q;
    for (int i = 0; i < 3; i++) begin
      full = (76'(phh[i]) << 38) + (76'(phl[i]) << 19) + (76'(plh[i]) << 19)
             + 76'(pll[i]);
      q = full[73:44];
      pq_c[i] = pneg2[i] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pm1   <= pm1_c;
      pneg1 <= pneg_c;
      pneg2 <= pneg1;
      for (int i = 0; i < 3; i++) begin
        phh[i] <= 38'(pm1[i][36:19]) * 38'(POS_RECIP[37:19]);
        phl[i] <= 38'(pm1[i][36:19]) * 38'(POS_RECIP[18:0]);
        plh[i] <= 38'(pm1[i][18:0]) * 38'(POS_RECIP[37:19]);
        pll[i] <= 38'(pm1[i][18:0]) * 38'(POS_RECIP[18:0]);
      end
      pd[2] <= pq_c;
      for (int k = QW; k > 2; k--) pd[k] <= pd[k-1];
    end
  end

  div_lane_t  dl [QW+1][LANES];
  side_t      sd [QW+1];
  logic [QW:0] vd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else if (adv) begin
      vd[0] <= vs[9];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl[0] <= prep_c;
      sd[0] <= s9_s;
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int K = QW - 1 - g;
    div_lane_t nx [LANES];
    always_comb begin
      logic [CW-1:0] sh;
      for (int j = 0; j < LANES; j++) begin
        nx[j] = dl[g][j];
        sh = CW'(dl[g][j].den) << K;
        if (g == 0) begin
          nx[j].ovf = (CW'(dl[g][j].rem) >= {dl[g][j].den, {QW{1'b0}}});
        end
        if (CW'(dl[g][j].rem) >= sh) begin
          nx[j].rem    = dl[g][j].rem - sh[NW-1:0];
          nx[j].quo[K] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[g+1] <= 1'b0;
      end else if (adv) begin
        vd[g+1] <= vd[g];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dl[g+1] <= nx;
        sd[g+1] <= sd[g];
      end
    end
  end

  // final add and saturate
  logic [5:0][31:0] res_c;
  always_comb begin
    logic [QW-1:0]        q;
    logic signed [QW:0]   qs;
    side_t                s;
    s = sd[QW];
    for (int j = 0; j < 3; j++) begin
      q  = dl[QW][j].ovf ? {QW{1'b1}} : dl[QW][j].quo;
      qs = dl[QW][j].neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      if (!s.active) begin
        res_c[j]   = s.pos[j];
        res_c[3+j] = s.vel[j];
      end else begin
        res_c[j]   = sat32(64'($signed(s.pos[j])) + 64'(pd[QW][j]));
        res_c[3+j] = s.mzero ? s.vel[j] : sat32(64'($signed(s.vel[j])) + 64'(qs));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vd[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.new_pos_x <= res_c[0];
      result.new_pos_y <= res_c[1];
      result.new_pos_z <= res_c[2];
      result.new_vel_x <= res_c[3];
      result.new_vel_y <= res_c[4];
      result.new_vel_z <= res_c[5];
    end
  end

endmodule
